### rtl/tbcq_pkg.sv
// Shared types and constants for the tile block command queue.
// Used by every module in rtl/; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package tbcq_pkg;

    // Queue sizing: the default depth and the largest depth supported
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int QUEUE_DEPTH_MAX = 16;
    localparam int CNT_W           = $clog2(QUEUE_DEPTH_MAX + 1);

    // Depth of the job queue between front and back
    localparam int JOBQ_DEPTH = 2;

    // Attribute bits of a tile word
    localparam int HFLIP_BIT = 11;
    localparam int VFLIP_BIT = 12;

    // Stored command operation
    localparam logic OP_DRAW  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Result kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_DROP  = 1'b1;

    typedef enum logic [1:0] {
        ACT_DRAW    = 2'd0,
        ACT_CLEAR   = 2'd1,
        ACT_FLUSH   = 2'd2,
        ACT_DISCARD = 2'd3
    } action_e;

    typedef enum logic [1:0] {
        JOB_EXPAND = 2'd0,
        JOB_DROP   = 2'd1,
        JOB_FLUSH  = 2'd2
    } job_kind_e;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_LOAD,
        BK_EXPAND,
        BK_DROP
    } back_state_e;

    // One 2x2 block command as held in the store
    typedef struct packed {
        logic        op;
        logic [1:0]  plane;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [15:0] word;
    } entry_t;

    // Work handed from front to back
    typedef struct packed {
        job_kind_e          kind;
        entry_t             entry;
        logic [CNT_W-1:0]   count;
    } job_t;

    // Store write request from front to back
    typedef struct packed {
        logic               en;
        logic [CNT_W-1:0]   addr;
        entry_t             entry;
    } store_wr_t;

    // One result item
    typedef struct packed {
        logic        kind;
        logic [1:0]  plane;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [15:0] word;
        logic        last;
    } result_t;

endpackage

`default_nettype wire

### rtl/tile_block_command_queue.sv
// Top level of the tile block command queue: front end, job queue, back end.
// Depends on tbcq_pkg, tbcq_front, tbcq_fifo and tbcq_back.
//
// Usage:
//   Input channel (in_valid / in_stall) carries commands: draw 2x2, clear 2x2,
//   vblank flush and discard. Output channel (out_valid / out_stall) carries
//   tilemap writes and queue-full drop reports; last marks the final result
//   of one command. cfg_wr_en / cfg_wr_data write queue_enable.
//   Timing: a command accepted with queueing off goes through the job queue,
//   cur_reg and the output register, then gives one write per cycle while the
//   output is not stalled (four in all). A stored command yields nothing and
//   the next item may follow in the next cycle. A flush fetches each stored
//   entry from the store's single read port in the BK_READ and BK_LOAD states
//   and then issues its four writes; input is stalled from the flush until
//   its last write sits in the output register.
//   The two-entry job queue lets commands enter while the back end works.
//   Reset clears queue_enable, the stored count and all handshake state.
//   A stalled output holds its item; the back end then stops and the input
//   stalls once the job queue is full.
`timescale 1ns / 1ps
`default_nettype none

module tile_block_command_queue
    import tbcq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  action,
    input  wire logic [1:0]  plane_sel,
    input  wire logic [7:0]  cell_x,
    input  wire logic [7:0]  cell_y,
    input  wire logic [15:0] tile_word,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             kind,
    output logic [1:0]       out_plane,
    output logic [7:0]       out_x,
    output logic [7:0]       out_y,
    output logic [15:0]      out_word,
    output logic             last
);

    logic      job_push;
    job_t      job;
    job_t      head;
    logic      jobq_full;
    logic      jobq_empty;
    logic      job_pop;
    store_wr_t store_wr;
    logic      flush_done;

    tbcq_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .plane_sel   (plane_sel),
        .cell_x      (cell_x),
        .cell_y      (cell_y),
        .tile_word   (tile_word),
        .jobq_full   (jobq_full),
        .job_push    (job_push),
        .job         (job),
        .store_wr    (store_wr),
        .flush_done  (flush_done)
    );

    tbcq_fifo u_jobq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (job),
        .pop      (job_pop),
        .head     (head),
        .full     (jobq_full),
        .empty    (jobq_empty)
    );

    tbcq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .store_wr   (store_wr),
        .head       (head),
        .jobq_empty (jobq_empty),
        .job_pop    (job_pop),
        .flush_done (flush_done),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .out_plane  (out_plane),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_word   (out_word),
        .last       (last)
    );

endmodule

`default_nettype wire

### rtl/tbcq_front.sv
// Front end: accepts items, classifies them, keeps the queue count and enable.
// Depends on tbcq_pkg; feeds tbcq_fifo with jobs and tbcq_back with store writes.
`timescale 1ns / 1ps
`default_nettype none

module tbcq_front
    import tbcq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  action,
    input  wire logic [1:0]  plane_sel,
    input  wire logic [7:0]  cell_x,
    input  wire logic [7:0]  cell_y,
    input  wire logic [15:0] tile_word,
    input  wire logic        jobq_full,
    output logic             job_push,
    output job_t             job,
    output store_wr_t        store_wr,
    input  wire logic        flush_done
);

    logic             queue_enable_reg;
    logic [CNT_W-1:0] entry_count_reg;
    logic [CNT_W-1:0] entry_count_next;
    logic             flush_busy_reg;
    logic             flush_busy_next;
    logic             accept;
    logic             queue_full;
    action_e          act;
    entry_t           cmd;

    // Hold off everything while the job queue is full or a flush replays the store
    assign in_stall   = jobq_full || flush_busy_reg;
    assign accept     = in_valid && !in_stall;
    assign act        = action_e'(action);
    assign queue_full = (entry_count_reg == CNT_W'(QUEUE_DEPTH));

    // Build the command; only a draw carries its tile word
    always_comb
    begin
        cmd.op    = action[0];
        cmd.plane = plane_sel;
        cmd.x     = cell_x;
        cmd.y     = cell_y;
        cmd.word  = (act == ACT_DRAW) ? tile_word : 16'd0;
    end

    // Classify the accepted item
    always_comb
    begin
        entry_count_next = entry_count_reg;
        flush_busy_next  = flush_busy_reg;
        job_push         = 1'b0;
        job.kind         = JOB_EXPAND;
        job.entry        = cmd;
        job.count        = entry_count_reg;
        store_wr.en      = 1'b0;
        store_wr.addr    = entry_count_reg;
        store_wr.entry   = cmd;

        if (flush_done)
        begin
            flush_busy_next = 1'b0;
        end

        if (accept)
        begin
            if (act inside {ACT_DRAW, ACT_CLEAR})
            begin
                if (!queue_enable_reg)
                begin
                    job_push = 1'b1;
                    job.kind = JOB_EXPAND;
                end
                else if (queue_full)
                begin
                    job_push = 1'b1;
                    job.kind = JOB_DROP;
                end
                else
                begin
                    store_wr.en      = 1'b1;
                    entry_count_next = entry_count_reg + 1'b1;
                end
            end
            else if (act == ACT_FLUSH)
            begin
                entry_count_next = '0;
                if (entry_count_reg != '0)
                begin
                    job_push        = 1'b1;
                    job.kind        = JOB_FLUSH;
                    flush_busy_next = 1'b1;
                end
            end
            else
            begin
                entry_count_next = '0;
            end
        end
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queue_enable_reg <= 1'b0;
            entry_count_reg  <= '0;
            flush_busy_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                queue_enable_reg <= cfg_wr_data;
            end
            entry_count_reg <= entry_count_next;
            flush_busy_reg  <= flush_busy_next;
        end
    end

    // The count never passes the configured depth
    assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    // The store is never written while a flush is replaying it
    assert property (@(posedge clk) disable iff (!rst_n)
        store_wr.en |-> !flush_busy_reg)
        else $error("store write during flush");

    // A job is only pushed when the job queue has room
    assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> !jobq_full)
        else $error("job push into full queue");

endmodule

`default_nettype wire

### rtl/tbcq_fifo.sv
// Short job queue that decouples the front end from the back end.
// Depends on tbcq_pkg for the job type and depth.
`timescale 1ns / 1ps
`default_nettype none

module tbcq_fifo
    import tbcq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output job_t      head,
    output logic      full,
    output logic      empty
);

    localparam int PTR_W = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
    localparam int FILL_W = $clog2(JOBQ_DEPTH + 1);

    job_t              slot_reg [JOBQ_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;

    assign full  = (fill_reg == FILL_W'(JOBQ_DEPTH));
    assign empty = (fill_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Store the pushed job
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty job queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(JOBQ_DEPTH))
        else $error("job queue overfilled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> !empty)
        else $error("job queue lost a push");

endmodule

`default_nettype wire

### rtl/tbcq_back.sv
// Back end: holds the command store, expands jobs into tilemap writes,
// replays the store on flush and drives the output register. Depends on tbcq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tbcq_back
    import tbcq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire store_wr_t    store_wr,
    input  wire job_t         head,
    input  wire logic         jobq_empty,
    output logic              job_pop,
    output logic              flush_done,
    output logic              out_valid,
    input  wire logic         out_stall,
    output logic              kind,
    output logic [1:0]        out_plane,
    output logic [7:0]        out_x,
    output logic [7:0]        out_y,
    output logic [15:0]       out_word,
    output logic              last
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [1:0] K_LAST = 2'd3;

    entry_t           store_mem [QUEUE_DEPTH];
    entry_t           rd_data_reg;

    back_state_e      state_reg;
    back_state_e      state_next;
    entry_t           cur_reg;
    entry_t           cur_next;
    logic [1:0]       k_reg;
    logic [1:0]       k_next;
    logic             flushing_reg;
    logic             flushing_next;
    logic [CNT_W-1:0] rd_idx_reg;
    logic [CNT_W-1:0] rd_idx_next;
    logic [CNT_W-1:0] total_reg;
    logic [CNT_W-1:0] total_next;
    logic             out_valid_reg;
    result_t          out_res_reg;
    logic             out_load;
    logic             emit;
    result_t          res;
    logic             hflip;
    logic             vflip;
    logic             more_entries;

    // Command store: written by the front end, read one entry per fetch
    always_ff @(posedge clk)
    begin
        if (store_wr.en)
        begin
            store_mem[store_wr.addr[AW-1:0]] <= store_wr.entry;
        end
        rd_data_reg <= store_mem[rd_idx_reg[AW-1:0]];
    end

    assign out_load     = !out_valid_reg || !out_stall;
    assign hflip        = (cur_reg.op == OP_DRAW) ? cur_reg.word[HFLIP_BIT] : 1'b0;
    assign vflip        = (cur_reg.op == OP_DRAW) ? cur_reg.word[VFLIP_BIT] : 1'b0;
    assign more_entries = flushing_reg && (CNT_W'(rd_idx_reg + 1'b1) != total_reg);

    // Sequence jobs and form results
    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        k_next        = k_reg;
        flushing_next = flushing_reg;
        rd_idx_next   = rd_idx_reg;
        total_next    = total_reg;
        job_pop       = 1'b0;
        flush_done    = 1'b0;
        emit          = 1'b0;

        res.kind  = KIND_WRITE;
        res.plane = cur_reg.plane;
        res.x     = cur_reg.x + {7'd0, k_reg[1] ^ hflip};
        res.y     = cur_reg.y + {7'd0, k_reg[0] ^ vflip};
        res.word  = (cur_reg.op == OP_DRAW) ? cur_reg.word + {14'd0, k_reg} : 16'd0;
        res.last  = (k_reg == K_LAST) && !more_entries;

        case (state_reg)
            BK_IDLE:
            begin
                if (!jobq_empty)
                begin
                    job_pop = 1'b1;
                    case (head.kind)
                        JOB_EXPAND:
                        begin
                            cur_next      = head.entry;
                            k_next        = '0;
                            flushing_next = 1'b0;
                            state_next    = BK_EXPAND;
                        end
                        JOB_DROP:
                        begin
                            cur_next   = head.entry;
                            state_next = BK_DROP;
                        end
                        JOB_FLUSH:
                        begin
                            rd_idx_next   = '0;
                            total_next    = head.count;
                            flushing_next = 1'b1;
                            state_next    = BK_READ;
                        end
                        default:
                        begin
                            state_next = BK_IDLE;
                        end
                    endcase
                end
            end
            BK_READ:
            begin
                state_next = BK_LOAD;
            end
            BK_LOAD:
            begin
                cur_next   = rd_data_reg;
                k_next     = '0;
                state_next = BK_EXPAND;
            end
            BK_EXPAND:
            begin
                if (out_load)
                begin
                    emit   = 1'b1;
                    k_next = k_reg + 1'b1;
                    if (k_reg == K_LAST)
                    begin
                        if (more_entries)
                        begin
                            rd_idx_next = rd_idx_reg + 1'b1;
                            state_next  = BK_READ;
                        end
                        else
                        begin
                            flush_done = flushing_reg;
                            state_next = BK_IDLE;
                        end
                    end
                end
            end
            BK_DROP:
            begin
                res.kind  = KIND_DROP;
                res.x     = cur_reg.x;
                res.y     = cur_reg.y;
                res.word  = cur_reg.word;
                res.last  = 1'b1;
                if (out_load)
                begin
                    emit       = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            k_reg         <= '0;
            flushing_reg  <= 1'b0;
            rd_idx_reg    <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            flushing_reg <= flushing_next;
            rd_idx_reg   <= rd_idx_next;
            total_reg    <= total_next;
            if (out_load)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    // Hold the current command and the output payload
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (out_load)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = out_res_reg.kind;
    assign out_plane = out_res_reg.plane;
    assign out_x     = out_res_reg.x;
    assign out_y     = out_res_reg.y;
    assign out_word  = out_res_reg.word;
    assign last      = out_res_reg.last;

    // Jobs are taken only between jobs
    assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> (state_reg == BK_IDLE))
        else $error("job popped while busy");

    // Flush completion only ends a replay
    assert property (@(posedge clk) disable iff (!rst_n)
        flush_done |-> flushing_reg)
        else $error("flush done outside a flush");

    // A replay never reads past the stored entries
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == BK_EXPAND) && flushing_reg) |-> (rd_idx_reg < total_reg))
        else $error("replay index past stored count");

endmodule

`default_nettype wire

### sim/tile_block_command_queue_checker.sv
// Checker for the tile block command queue: tracks queue_enable and the deferred
// commands, predicts every tilemap write and drop report, and compares them.
// Depends on tbcq_pkg for the action codes, the entry layout and the result layout.
`timescale 1ns / 1ps

module tile_block_command_queue_checker
    import tbcq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  action,
    input  logic [1:0]  plane_sel,
    input  logic [7:0]  cell_x,
    input  logic [7:0]  cell_y,
    input  logic [15:0] tile_word,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        kind,
    input  logic [1:0]  out_plane,
    input  logic [7:0]  out_x,
    input  logic [7:0]  out_y,
    input  logic [15:0] out_word,
    input  logic        last,
    output int          fail_count,
    output int          pending
);

    localparam int REPORT_LIMIT = 10;

    logic    defer_on;
    entry_t  deferred_cmds [QUEUE_DEPTH_MAX];
    int      deferred_count;
    result_t tile_writes_due [$];
    int      reported;

    // Queue the four writes of one block command, flip order for draws only
    task automatic expand_block(input entry_t cmd, input logic ends_item);
        result_t wr;
        logic    hf;
        logic    vf;
        hf = (cmd.op == OP_DRAW) ? cmd.word[HFLIP_BIT] : 1'b0;
        vf = (cmd.op == OP_DRAW) ? cmd.word[VFLIP_BIT] : 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            wr.kind  = KIND_WRITE;
            wr.plane = cmd.plane;
            wr.x     = 8'(cmd.x + ((k >> 1) ^ hf));
            wr.y     = 8'(cmd.y + ((k & 1) ^ vf));
            wr.word  = (cmd.op == OP_DRAW) ? 16'(cmd.word + k) : 16'd0;
            wr.last  = ends_item && (k == 3);
            tile_writes_due.push_back(wr);
        end
    endtask

    // Apply one accepted item to the deferred queue and predict its writes
    task automatic apply_command();
        entry_t  cmd;
        result_t drop;
        cmd.op    = (action == ACT_CLEAR) ? OP_CLEAR : OP_DRAW;
        cmd.plane = plane_sel;
        cmd.x     = cell_x;
        cmd.y     = cell_y;
        cmd.word  = (action == ACT_DRAW) ? tile_word : 16'd0;
        case (action)
            ACT_DRAW, ACT_CLEAR:
            begin
                if (!defer_on)
                begin
                    expand_block(cmd, 1'b1);
                end
                else if (deferred_count >= QUEUE_DEPTH)
                begin
                    // Queue full: report the command back instead of storing it
                    drop.kind  = KIND_DROP;
                    drop.plane = cmd.plane;
                    drop.x     = cmd.x;
                    drop.y     = cmd.y;
                    drop.word  = cmd.word;
                    drop.last  = 1'b1;
                    tile_writes_due.push_back(drop);
                end
                else
                begin
                    deferred_cmds[deferred_count] = cmd;
                    deferred_count++;
                end
            end
            ACT_FLUSH:
            begin
                for (int i = 0; i < deferred_count; i++)
                begin
                    expand_block(deferred_cmds[i], i == deferred_count - 1);
                end
                deferred_count = 0;
            end
            default:
            begin
                deferred_count = 0;
            end
        endcase
    endtask

    // Compare one accepted result with the oldest prediction
    task automatic check_write();
        result_t want;
        logic    bad;
        if (tile_writes_due.size() == 0)
        begin
            fail_count++;
            if (reported < REPORT_LIMIT)
            begin
                reported++;
                $display("%0t: unexpected result kind %0d plane %0d x %0d y %0d word %h last %0d",
                         $realtime, kind, out_plane, out_x, out_y, out_word, last);
            end
        end
        else
        begin
            want = tile_writes_due.pop_front();
            bad  = (kind !== want.kind) || (out_plane !== want.plane) ||
                   (out_x !== want.x) || (out_y !== want.y) ||
                   (out_word !== want.word) || (last !== want.last);
            if (bad)
            begin
                fail_count++;
                if (reported < REPORT_LIMIT)
                begin
                    reported++;
                    $display("%0t: mismatch, expected kind %0d plane %0d x %0d y %0d word %h last %0d",
                             $realtime, want.kind, want.plane, want.x, want.y, want.word,
                             want.last);
                    $display("%0t:           got kind %0d plane %0d x %0d y %0d word %h last %0d",
                             $realtime, kind, out_plane, out_x, out_y, out_word, last);
                end
            end
        end
    endtask

    // Track configuration, predict on input handshakes, check on output ones
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            defer_on       = 1'b0;
            deferred_count = 0;
            tile_writes_due.delete();
            fail_count     = 0;
            reported       = 0;
            pending        = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                defer_on = cfg_wr_data;
            end
            if (in_valid && !in_stall)
            begin
                apply_command();
            end
            if (out_valid && !out_stall)
            begin
                check_write();
            end
            pending = tile_writes_due.size();
        end
    end

endmodule

### sim/tile_block_command_queue_test.sv
// Top of the tile block command queue testbench: clock, reset, stimulus, verdict.
// Depends on tbcq_pkg, tile_block_command_queue and tile_block_command_queue_checker.
`timescale 1ns / 1ps

module tile_block_command_queue_test;
    import tbcq_pkg::*;

    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 310;
    localparam int NUM_PHASES   = 8;
    localparam int QUIET_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 1_000_000;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    action_e     action      = ACT_DRAW;
    logic [1:0]  plane_sel   = 2'd0;
    logic [7:0]  cell_x      = 8'd0;
    logic [7:0]  cell_y      = 8'd0;
    logic [15:0] tile_word   = 16'd0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic        kind;
    logic [1:0]  out_plane;
    logic [7:0]  out_x;
    logic [7:0]  out_y;
    logic [15:0] out_word;
    logic        last;

    int fail_count;
    int pending;
    int burst_left  = 0;
    int stall_mode  = 0;
    int stall_left  = 0;
    int cycle_count = 0;

    tile_block_command_queue DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .plane_sel   (plane_sel),
        .cell_x      (cell_x),
        .cell_y      (cell_y),
        .tile_word   (tile_word),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .out_plane   (out_plane),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_word    (out_word),
        .last        (last)
    );

    tile_block_command_queue_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .plane_sel   (plane_sel),
        .cell_x      (cell_x),
        .cell_y      (cell_y),
        .tile_word   (tile_word),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .out_plane   (out_plane),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_word    (out_word),
        .last        (last),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver stall: stretches of random mode, from never stalling to mostly stalling
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(8, 60);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 1) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Drive one item, with a random gap at the start of each burst
    task automatic send(input action_e act, input logic [1:0] pl, input logic [7:0] x,
                        input logic [7:0] y, input logic [15:0] w);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        in_valid  <= 1'b1;
        action    <= act;
        plane_sel <= pl;
        cell_x    <= x;
        cell_y    <= y;
        tile_word <= w;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_random(input action_e act);
        send(act, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
             8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
    endtask

    task automatic send_random_block();
        send_random(($urandom_range(0, 2) == 0) ? ACT_CLEAR : ACT_DRAW);
    endtask

    // Drop valid, wait for every predicted result, then let the block go quiet
    task automatic settle();
        in_valid   <= 1'b0;
        burst_left = 0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic set_queue_mode(input logic en);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= en;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Deferred mode: runs of commands, some overfilling, mostly closed by a flush or discard
    task automatic run_deferred_phase(input int budget);
        int done_items;
        int run_len;
        int close;
        done_items = 0;
        while (done_items < budget)
        begin
            run_len = ($urandom_range(0, 5) == 0) ?
                      $urandom_range(QUEUE_DEPTH_DEF + 1, QUEUE_DEPTH_DEF + 4) :
                      $urandom_range(0, QUEUE_DEPTH_DEF);
            repeat (run_len) send_random_block();
            close = $urandom_range(0, 9);
            if (close < 7)
            begin
                send_random(ACT_FLUSH);
            end
            else if (close < 9)
            begin
                send_random(ACT_DISCARD);
            end
            done_items += run_len + 1;
        end
    endtask

    // Immediate mode: mostly draws and clears, with flushes and discards mixed in
    task automatic run_direct_phase(input int budget);
        int pick;
        repeat (budget)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
            begin
                send_random(ACT_DRAW);
            end
            else if (pick < 7)
            begin
                send_random(ACT_CLEAR);
            end
            else if (pick < 9)
            begin
                send_random(ACT_FLUSH);
            end
            else
            begin
                send_random(ACT_DISCARD);
            end
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        int phase_mode;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Immediate writes: coordinate and word wrap, each flip, clear ignoring flips
        send(ACT_DRAW, 2'd0, 8'd255, 8'd255, 16'hFFFE);
        send(ACT_DRAW, 2'd1, 8'd16, 8'd32, 16'h0805);
        send(ACT_DRAW, 2'd2, 8'd0, 8'd255, 16'h1000);
        send(ACT_DRAW, 2'd3, 8'd255, 8'd0, 16'hFFFF);
        send(ACT_CLEAR, 2'd3, 8'd255, 8'd255, 16'h1800);
        settle();

        // Deferred: fill the queue, overflow with a draw and a clear, flush it all
        set_queue_mode(1'b1);
        repeat (QUEUE_DEPTH_DEF) send_random_block();
        send(ACT_DRAW, 2'd2, 8'd255, 8'd0, 16'hABCD);
        send(ACT_CLEAR, 2'd1, 8'd0, 8'd255, 16'hFFFF);
        send_random(ACT_FLUSH);
        // Discard drops a stored command; the following flush finds nothing
        send_random_block();
        send_random(ACT_DISCARD);
        send_random(ACT_FLUSH);
        settle();

        // Random phases; entries left stored carry over into immediate phases
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            phase_mode = (p < 2) ? p : $urandom_range(0, 1);
            set_queue_mode(phase_mode[0]);
            if (phase_mode != 0)
            begin
                run_deferred_phase(RANDOM_ITEMS / NUM_PHASES);
            end
            else
            begin
                run_direct_phase(RANDOM_ITEMS / NUM_PHASES);
            end
            settle();
        end

        if (fail_count == 0 && pending == 0)
        begin
            $display("tile_block_command_queue_test: PASS");
        end
        else
        begin
            $display("tile_block_command_queue_test: FAIL");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tile_block_command_queue_test: FAIL");
        $finish;
    end

endmodule

### tile_block_command_queue.f
rtl/tbcq_pkg.sv
rtl/tbcq_front.sv
rtl/tbcq_fifo.sv
rtl/tbcq_back.sv
rtl/tile_block_command_queue.sv
sim/tile_block_command_queue_checker.sv
sim/tile_block_command_queue_test.sv
